// ===== sv/bf33_pkg.sv =====
// ----------------------------------------------------------------------------
// bf33_pkg
// Shared types and constants of the 3x3 border-clipped box filter.
// ----------------------------------------------------------------------------
package bf33_pkg;

    localparam int PIX_W = 8;
    localparam int SUM_W = 12;              // nine pixels of 8 bits
    localparam int COLSUM_W = 10;           // three pixels of 8 bits
    localparam int SIZE_W = 6;
    localparam int POS_W = 5;
    localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 6'd10;

    // reciprocals scaled by 2^16, rounded up; exact for every possible sum
    localparam int RECIP_W = 14;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_6 = 14'd10923;
    localparam logic [RECIP_W-1:0] RECIP_9 = 14'd7282;

    // one image column as seen by the window: three rows of pixels
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] lower;
    } pix3_t;

    typedef enum logic [1:0] {
        DIV_4,
        DIV_6,
        DIV_9
    } div_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_ROT
    } state_t;

endpackage

// ===== sv/box_filter_3x3_border_clipped.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_border_clipped
// 3x3 box filter over a square image streamed in raster order; neighborhoods
// are clipped at the image border.
// ----------------------------------------------------------------------------
// Pixels enter one word at a time on s_*, smoothed words leave on m_* with
// their row and column. The image side comes from cfg_wr_data (2..MAX_WIDTH,
// values outside are clamped); a write restarts the frame at pixel (0,0).
// Two previous rows live in a chain of MAX_WIDTH column cells that advances
// once per pixel and during the bottom-row replay; there is no clearing pass
// after reset. Results are built one at a time by a shared window adder and
// constant divider: a pixel right of the first column and below the top row
// yields one result, the last pixel of such a row yields two, and the
// frame's last pixel also replays the bottom row through the chain for one
// result per column.
// ----------------------------------------------------------------------------
module box_filter_3x3_border_clipped #(
    parameter int MAX_WIDTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_pixel,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_smoothed,
    output logic [4:0] m_out_row,
    output logic [4:0] m_out_col,
    output logic       m_last_of_run,
    output logic       m_frame_done
);

    localparam int NW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (NW > bf33_pkg::POS_W) ? NW : bf33_pkg::POS_W;
    localparam int TW = $clog2(MAX_WIDTH);
    // third cell of the chain; its column is never valid when the chain is shorter
    localparam int L2 = (MAX_WIDTH > 2) ? 2 : MAX_WIDTH - 1;

    bf33_pkg::state_t state_reg, state_next;

    logic [bf33_pkg::SIZE_W-1:0] image_size_reg;
    logic [CW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [CW-1:0] jc_reg, jc_next;
    logic [CW-1:0] ev_row_reg, ev_row_next;
    logic [CW-1:0] rot_cnt_reg, rot_cnt_next;
    logic          upper_en_reg, upper_en_next;
    logic          flush_reg, flush_next;
    logic          last_px_reg, last_px_next;
    logic          phase_reg, phase_next;
    logic [bf33_pkg::SUM_W-1:0] sum_reg, sum_next;
    bf33_pkg::div_t             div_reg, div_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_smoothed_reg, m_smoothed_next;
    logic [4:0] m_out_row_reg, m_out_row_next;
    logic [4:0] m_out_col_reg, m_out_col_next;
    logic       m_last_reg, m_last_next;
    logic       m_done_reg, m_done_next;

    logic [6:0]    size7;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] n_m1;

    bf33_pkg::pix3_t cell_q  [MAX_WIDTH];
    bf33_pkg::pix3_t chain_d [MAX_WIDTH];
    bf33_pkg::pix3_t head_d;
    bf33_pkg::pix3_t tap;
    logic            shift_en;

    bf33_pkg::pix3_t win_l, win_c, win_r;
    logic            left_ok, right_ok;
    logic [bf33_pkg::COLSUM_W-1:0] colsum_l, colsum_c, colsum_r;
    logic [bf33_pkg::PIX_W-1:0]    mean;
    logic                          in_acc;
    logic                          out_free;

    // effective image side
    assign size7 = {1'b0, image_size_reg};
    always_comb begin
        if (size7 < 7'd2) begin
            n_eff = CW'(2);
        end else if (size7 > 7'(MAX_WIDTH)) begin
            n_eff = CW'(MAX_WIDTH);
        end else begin
            n_eff = size7[CW-1:0];
        end
    end
    assign n_m1 = n_eff - CW'(1);

    // column chain
    assign tap = cell_q[n_m1[TW-1:0]];
    assign chain_d[0] = head_d;

    genvar g;
    generate
        for (g = 0; g < MAX_WIDTH; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign chain_d[g] = cell_q[g-1];
            end
            bf33_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_i      (chain_d[g]),
                .q_o      (cell_q[g])
            );
        end
    endgenerate

    // window around the result column: phase 0 centers on cell 1, phase 1 on cell 0
    always_comb begin
        if (!phase_reg) begin
            win_l    = cell_q[L2];
            win_c    = cell_q[1];
            win_r    = cell_q[0];
            left_ok  = (jc_reg >= CW'(2));
            right_ok = 1'b1;
        end else begin
            win_l    = cell_q[1];
            win_c    = cell_q[0];
            win_r    = cell_q[0];
            left_ok  = 1'b1;
            right_ok = 1'b0;
        end
    end

    assign colsum_l = (upper_en_reg ? bf33_pkg::COLSUM_W'(win_l.upper) : '0)
                    + bf33_pkg::COLSUM_W'(win_l.middle) + bf33_pkg::COLSUM_W'(win_l.lower);
    assign colsum_c = (upper_en_reg ? bf33_pkg::COLSUM_W'(win_c.upper) : '0)
                    + bf33_pkg::COLSUM_W'(win_c.middle) + bf33_pkg::COLSUM_W'(win_c.lower);
    assign colsum_r = (upper_en_reg ? bf33_pkg::COLSUM_W'(win_r.upper) : '0)
                    + bf33_pkg::COLSUM_W'(win_r.middle) + bf33_pkg::COLSUM_W'(win_r.lower);

    bf33_mean u_mean (
        .sum_i  (sum_reg),
        .div_i  (div_reg),
        .mean_o (mean)
    );

    assign s_ready  = (state_reg == bf33_pkg::S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        row_cnt_next    = row_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        jc_next         = jc_reg;
        ev_row_next     = ev_row_reg;
        rot_cnt_next    = rot_cnt_reg;
        upper_en_next   = upper_en_reg;
        flush_next      = flush_reg;
        last_px_next    = last_px_reg;
        phase_next      = phase_reg;
        sum_next        = sum_reg;
        div_next        = div_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_smoothed_next = m_smoothed_reg;
        m_out_row_next  = m_out_row_reg;
        m_out_col_next  = m_out_col_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        shift_en        = 1'b0;
        head_d          = tap;

        case (state_reg)
            bf33_pkg::S_IDLE: begin
                head_d = '{upper: tap.middle, middle: tap.lower, lower: s_pixel};
                if (in_acc) begin
                    shift_en      = 1'b1;
                    jc_next       = col_cnt_reg;
                    ev_row_next   = row_cnt_reg - CW'(1);
                    upper_en_next = (row_cnt_reg >= CW'(2));
                    last_px_next  = (row_cnt_reg == n_m1) && (col_cnt_reg == n_m1);
                    flush_next    = 1'b0;
                    phase_next    = 1'b0;
                    if (col_cnt_reg == n_m1) begin
                        col_cnt_next = '0;
                        row_cnt_next = (row_cnt_reg == n_m1) ? '0 : row_cnt_reg + CW'(1);
                    end else begin
                        col_cnt_next = col_cnt_reg + CW'(1);
                    end
                    if (row_cnt_reg != '0 && col_cnt_reg != '0) begin
                        state_next = bf33_pkg::S_SUM;
                    end
                end
            end
            bf33_pkg::S_SUM: begin
                sum_next = bf33_pkg::SUM_W'(colsum_c)
                         + (left_ok  ? bf33_pkg::SUM_W'(colsum_l) : '0)
                         + (right_ok ? bf33_pkg::SUM_W'(colsum_r) : '0);
                // both directions clipped to two lines: corner; one clipped: edge
                if (upper_en_reg && left_ok && right_ok) begin
                    div_next = bf33_pkg::DIV_9;
                end else if (upper_en_reg || (left_ok && right_ok)) begin
                    div_next = bf33_pkg::DIV_6;
                end else begin
                    div_next = bf33_pkg::DIV_4;
                end
                state_next = bf33_pkg::S_DIV;
            end
            bf33_pkg::S_DIV: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_smoothed_next = mean;
                    m_out_row_next  = ev_row_reg[4:0];
                    m_out_col_next  = phase_reg ? jc_reg[4:0] : jc_reg[4:0] - 5'd1;
                    m_done_next     = flush_reg && phase_reg;
                    m_last_next     = 1'b0;
                    if (!phase_reg && jc_reg == n_m1) begin
                        phase_next = 1'b1;
                        state_next = bf33_pkg::S_SUM;
                    end else if (flush_reg) begin
                        if (rot_cnt_reg == n_eff) begin
                            flush_next  = 1'b0;
                            m_last_next = 1'b1;
                            state_next  = bf33_pkg::S_IDLE;
                        end else begin
                            state_next = bf33_pkg::S_ROT;
                        end
                    end else if (last_px_reg) begin
                        // replay the bottom row through the chain
                        flush_next    = 1'b1;
                        rot_cnt_next  = '0;
                        ev_row_next   = n_m1;
                        upper_en_next = 1'b0;
                        state_next    = bf33_pkg::S_ROT;
                    end else begin
                        m_last_next = 1'b1;
                        state_next  = bf33_pkg::S_IDLE;
                    end
                end
            end
            bf33_pkg::S_ROT: begin
                shift_en     = 1'b1;
                jc_next      = rot_cnt_reg;
                rot_cnt_next = rot_cnt_reg + CW'(1);
                phase_next   = 1'b0;
                state_next   = (rot_cnt_reg == '0) ? bf33_pkg::S_ROT : bf33_pkg::S_SUM;
            end
            default: begin
                state_next = bf33_pkg::S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bf33_pkg::S_IDLE;
            image_size_reg <= bf33_pkg::IMAGE_SIZE_RESET;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            flush_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                image_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        jc_reg         <= jc_next;
        ev_row_reg     <= ev_row_next;
        rot_cnt_reg    <= rot_cnt_next;
        upper_en_reg   <= upper_en_next;
        last_px_reg    <= last_px_next;
        phase_reg      <= phase_next;
        sum_reg        <= sum_next;
        div_reg        <= div_next;
        m_smoothed_reg <= m_smoothed_next;
        m_out_row_reg  <= m_out_row_next;
        m_out_col_reg  <= m_out_col_next;
        m_last_reg     <= m_last_next;
        m_done_reg     <= m_done_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_smoothed    = m_smoothed_reg;
    assign m_out_row     = m_out_row_reg;
    assign m_out_col     = m_out_col_reg;
    assign m_last_of_run = m_last_reg;
    assign m_frame_done  = m_done_reg;

    // the bottom-right word always closes the run of the frame's last pixel
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_last_of_run)
        else $error("frame_done without last_of_run");

    // a pixel in the top row yields no word
    a_top_row_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && row_cnt_reg == '0 |=> state_reg == bf33_pkg::S_IDLE)
        else $error("top row pixel started a result");

    // the right-edge window is only taken at the last column
    a_phase_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bf33_pkg::S_SUM && phase_reg |-> jc_reg == n_m1)
        else $error("edge window away from last column");

    // the row replay never runs past the image side
    a_rot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bf33_pkg::S_ROT |-> rot_cnt_reg < n_eff && flush_reg)
        else $error("bottom row replay overrun");

endmodule

// ===== sv/bf33_cell.sv =====
// ----------------------------------------------------------------------------
// bf33_cell
// One column slot of the line chain: holds a column of three pixels and
// passes it on to the next slot whenever the chain advances.
// ----------------------------------------------------------------------------
module bf33_cell (
    input  logic             aclk,
    input  logic             shift_en,
    input  bf33_pkg::pix3_t  d_i,
    output bf33_pkg::pix3_t  q_o
);

    bf33_pkg::pix3_t col_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= d_i;
        end
    end

    assign q_o = col_reg;

endmodule

// ===== sv/bf33_mean.sv =====
// ----------------------------------------------------------------------------
// bf33_mean
// Truncated mean of a window sum over 4, 6 or 9 pixels, by shift or by
// multiplication with a scaled reciprocal.
// ----------------------------------------------------------------------------
module bf33_mean (
    input  logic [bf33_pkg::SUM_W-1:0] sum_i,
    input  bf33_pkg::div_t             div_i,
    output logic [bf33_pkg::PIX_W-1:0] mean_o
);

    localparam int PROD_W = bf33_pkg::SUM_W + bf33_pkg::RECIP_W;

    logic [bf33_pkg::RECIP_W-1:0] recip;
    logic [PROD_W-1:0]            prod;

    always_comb begin
        case (div_i)
            bf33_pkg::DIV_6: recip = bf33_pkg::RECIP_6;
            bf33_pkg::DIV_9: recip = bf33_pkg::RECIP_9;
            default:         recip = bf33_pkg::RECIP_9;
        endcase
    end

    assign prod = PROD_W'(sum_i) * PROD_W'(recip);

    always_comb begin
        case (div_i)
            bf33_pkg::DIV_4: mean_o = sum_i[2 +: bf33_pkg::PIX_W];
            default:         mean_o = prod[bf33_pkg::RECIP_SHIFT +: bf33_pkg::PIX_W];
        endcase
    end

endmodule

// ===== tb/sv/box_filter_3x3_border_clipped_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_border_clipped_test
// Self-checking testbench for the 3x3 border-clipped box filter.
// ----------------------------------------------------------------------------
// A short table of directed pixels and size writes comes first. It covers
// flat frames at both pixel extremes, sizes below the legal range,
// and a size write in the middle of a frame. Random frames and partial frames
// of mostly small sizes follow. Every smoothed word is checked against a
// behavioral line-store model. Both handshakes idle at random, and the
// output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module box_filter_3x3_border_clipped_test;

    localparam int LINE_DEPTH = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 128;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 204;
    localparam int MAX_REPORTS = 10;
    localparam int DIRECTED_ROWS = 31;

    typedef enum logic {
        ROW_PIXEL,
        ROW_SIZE
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] value;
        logic       fixed;
        logic [7:0] fixed_mean;
    } stim_row_t;

    typedef struct packed {
        logic [bf33_pkg::PIX_W-1:0] smoothed;
        logic [bf33_pkg::POS_W-1:0] row;
        logic [bf33_pkg::POS_W-1:0] col;
        logic                       last_of_run;
        logic                       frame_done;
    } smoothed_word_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [bf33_pkg::SIZE_W-1:0] cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [bf33_pkg::PIX_W-1:0]  s_pixel;
    logic                        m_valid;
    logic                        m_ready;
    logic [bf33_pkg::PIX_W-1:0]  m_smoothed;
    logic [bf33_pkg::POS_W-1:0]  m_out_row;
    logic [bf33_pkg::POS_W-1:0]  m_out_col;
    logic                        m_last_of_run;
    logic                        m_frame_done;

    // model of the filter: three lines, next pixel position, side register
    logic [7:0]                  line_two_up [LINE_DEPTH];
    logic [7:0]                  line_one_up [LINE_DEPTH];
    logic [7:0]                  line_now [LINE_DEPTH];
    int                          next_row;
    int                          next_col;
    logic [bf33_pkg::SIZE_W-1:0] side_reg;

    smoothed_word_t    smoothed_due [$];
    int                n_mismatches = 0;
    int                idle_cycles = 0;
    bit                tx_burst = 1'b0;
    bit                rx_burst = 1'b0;
    bit                hold_request = 1'b0;

    // size, four flat 255s, size, four flat 0s, size-3 partial frame,
    // restart at size 2, then a full checkerboard frame of size 3
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SIZE,  8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b1, 8'd255},
        '{ROW_SIZE,  8'd1,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b1, 8'd0},
        '{ROW_SIZE,  8'd3,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd1,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd2,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd4,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd8,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd16,  1'b0, 8'd0},
        '{ROW_SIZE,  8'd2,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd128, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd127, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd1,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd254, 1'b0, 8'd0},
        '{ROW_SIZE,  8'd3,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0},
        '{ROW_PIXEL, 8'd0,   1'b0, 8'd0},
        '{ROW_PIXEL, 8'd255, 1'b0, 8'd0}
    };

    box_filter_3x3_border_clipped #(
        .MAX_WIDTH(LINE_DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pixel(s_pixel),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_smoothed(m_smoothed),
        .m_out_row(m_out_row),
        .m_out_col(m_out_col),
        .m_last_of_run(m_last_of_run),
        .m_frame_done(m_frame_done)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int effective_side(input logic [bf33_pkg::SIZE_W-1:0] raw);
        int s;
        s = raw;
        if (s < 2) s = 2;
        if (s > LINE_DEPTH) s = LINE_DEPTH;
        return s;
    endfunction

    // neighborhood clipped at the image border and to the rows still held
    function automatic logic [7:0] clipped_mean(input int r, input int c,
                                                input int cur, input int n);
        int total;
        int cnt;
        int k;
        int q;
        total = 0;
        cnt = 0;
        for (k = r - 1; k <= r + 1; k++) begin
            if (k >= 0 && k < n && k <= cur && k >= cur - 2) begin
                for (q = c - 1; q <= c + 1; q++) begin
                    if (q >= 0 && q < n) begin
                        if (k == cur) total += line_now[q];
                        else if (k == cur - 1) total += line_one_up[q];
                        else total += line_two_up[q];
                        cnt++;
                    end
                end
            end
        end
        return (cnt == 0) ? 8'd0 : 8'(total / cnt);
    endfunction

    function automatic smoothed_word_t make_word(input int r, input int c, input int cur,
                                                 input int n, input logic done);
        smoothed_word_t w;
        w.smoothed = clipped_mean(r, c, cur, n);
        w.row = r[bf33_pkg::POS_W-1:0];
        w.col = c[bf33_pkg::POS_W-1:0];
        w.last_of_run = 1'b0;
        w.frame_done = done;
        return w;
    endfunction

    task automatic predict_pixel(input logic [7:0] px, input logic fixed,
                                 input logic [7:0] fixed_mean);
        smoothed_word_t batch [$];
        smoothed_word_t w;
        int n;
        int i;
        int j;
        int c;
        n = effective_side(side_reg);
        i = next_row;
        j = next_col;
        if (i >= n || j >= n) begin
            i = 0;
            j = 0;
        end
        line_now[j] = px;
        if (i >= 1 && j >= 1) batch.push_back(make_word(i - 1, j - 1, i, n, 1'b0));
        if (i >= 1 && j == n - 1) batch.push_back(make_word(i - 1, n - 1, i, n, 1'b0));
        // last pixel of the frame flushes the bottom row
        if (i == n - 1 && j == n - 1) begin
            for (c = 0; c < n; c++) batch.push_back(make_word(n - 1, c, i, n, c == n - 1));
        end
        foreach (batch[x]) begin
            w = batch[x];
            w.last_of_run = (x == batch.size() - 1);
            if (fixed) w.smoothed = fixed_mean;
            smoothed_due.push_back(w);
        end
        j++;
        if (j >= n) begin
            j = 0;
            line_two_up = line_one_up;
            line_one_up = line_now;
            i++;
            if (i >= n) i = 0;
        end
        next_row = i;
        next_col = j;
    endtask

    task automatic log_mismatch(input string msg);
        n_mismatches++;
        if (n_mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic push_pixel(input logic [7:0] px, input logic fixed,
                              input logic [7:0] fixed_mean);
        int gap;
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(px, fixed, fixed_mean);
    endtask

    // stop offering words and let the filter run dry
    task automatic quiesce();
        s_valid <= 1'b0;
        while (smoothed_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_side(input logic [bf33_pkg::SIZE_W-1:0] v);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        side_reg = v;
        next_row = 0;
        next_col = 0;
    endtask

    initial begin : stimulus
        stim_row_t   cur_row;
        int          seg;
        int          random_sent;
        int          size_val;
        int          n;
        int          pix_count;
        int          pick;
        int          k;
        logic [7:0]  px;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_pixel <= '0;
        side_reg = bf33_pkg::IMAGE_SIZE_RESET;
        next_row = 0;
        next_col = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            cur_row = directed_rows[k];
            if (cur_row.kind == ROW_SIZE) begin
                write_side(cur_row.value[bf33_pkg::SIZE_W-1:0]);
            end else begin
                push_pixel(cur_row.value, cur_row.fixed, cur_row.fixed_mean);
            end
        end

        seg = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (seg)
                0: begin
                    size_val = 6;
                    pix_count = 72;
                end
                // above the range, clamps to the widest line
                1: begin
                    size_val = 63;
                    pix_count = 36;
                end
                2: begin
                    size_val = LINE_DEPTH;
                    pix_count = 34;
                end
                default: begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0) size_val = $urandom_range(0, 1);
                    else if (pick == 1) size_val = $urandom_range(33, 63);
                    else size_val = $urandom_range(2, 7);
                    n = effective_side(size_val[bf33_pkg::SIZE_W-1:0]);
                    if (n > 8) pix_count = $urandom_range(n + 2, n + 8);
                    else if ($urandom_range(0, 3) == 0) pix_count = $urandom_range(1, n * n - 1);
                    else pix_count = n * n * $urandom_range(1, 2);
                end
            endcase
            write_side(size_val[bf33_pkg::SIZE_W-1:0]);
            tx_burst = (seg == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
            // long output stall while the input keeps streaming
            if (seg == 0) hold_request = 1'b1;
            for (k = 0; k < pix_count && random_sent < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 7);
                if (pick == 0) px = 8'd0;
                else if (pick == 1) px = 8'd255;
                else px = 8'($urandom_range(0, 255));
                push_pixel(px, 1'b0, 8'd0);
                random_sent++;
            end
            seg++;
        end

        s_valid <= 1'b0;
        while (smoothed_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_mismatches == 0 && smoothed_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : result_side
        smoothed_word_t got;
        smoothed_word_t want;
        int             gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.smoothed = m_smoothed;
            got.row = m_out_row;
            got.col = m_out_col;
            got.last_of_run = m_last_of_run;
            got.frame_done = m_frame_done;
            if (smoothed_due.size() == 0) begin
                log_mismatch($sformatf("unexpected word: mean %0d at (%0d,%0d) last %b done %b",
                    got.smoothed, got.row, got.col, got.last_of_run, got.frame_done));
            end else begin
                want = smoothed_due.pop_front();
                if (got !== want) begin
                    log_mismatch($sformatf(
                        "expected mean %0d (%0d,%0d) last %b done %b, got %0d (%0d,%0d) %b %b",
                        want.smoothed, want.row, want.col, want.last_of_run, want.frame_done,
                        got.smoothed, got.row, got.col, got.last_of_run, got.frame_done));
                end
            end
        end
    end

    // watchdog on cycles with no word moving and no size write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
